### src/edit_distance_engine_core_assert.svh
// Assertion macros shared by the edit distance engine RTL.
`ifndef EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH
`define EDIT_DISTANCE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define EDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define EDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/edc_pkg.sv
// Shared types and constants of the edit distance engine.
`default_nettype none

package edc_pkg;

    // Field widths fixed by the interface
    localparam int SYM_W  = 8;
    localparam int DIST_W = 7;

    // Largest distance the result field can carry
    localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

    // Operation codes of an input beat
    localparam logic OP_REF  = 1'b0;
    localparam logic OP_CAND = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // input beat accepted this cycle
        logic step;   // advance the cost-row sweep
        logic emit;   // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sweep_go;   // offered beat is a candidate char that needs a sweep
        logic res_now;    // offered beat is the last candidate char
        logic sweep_end;  // final cell of the row is written this cycle
        logic res_pend;   // the beat in the sweep ends the candidate
        logic out_busy;   // result register full and stalled
    } t_sts;

endpackage

`default_nettype wire

### src/edc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module edc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic                                       i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/edc_ctrl.sv
// Controller state machine of the edit distance engine.
`default_nettype none
`include "edit_distance_engine_core_assert.svh"

module edc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire edc_pkg::t_sts i_sts,
    output edc_pkg::t_cmd      o_cmd
);

    edc_pkg::t_state r_state;
    edc_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= edc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            edc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.sweep_go) begin
                        n_state = edc_pkg::ST_SWEEP;
                    end else if (i_sts.res_now) begin
                        n_state = edc_pkg::ST_DONE;
                    end
                end
            end
            edc_pkg::ST_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = i_sts.res_pend ? edc_pkg::ST_DONE : edc_pkg::ST_IDLE;
                end
            end
            edc_pkg::ST_DONE: begin
                // wait for room in the result register
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = edc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = edc_pkg::ST_IDLE;
            end
        endcase
    end

    `EDC_ASSERT_NOW(a_end_in_sweep, i_sts.sweep_end, r_state == edc_pkg::ST_SWEEP, "row end outside sweep")

endmodule

`default_nettype wire

### src/edc_dp.sv
// Datapath of the edit distance engine: word state, cost-row sweep and result register.
`default_nettype none
`include "edit_distance_engine_core_assert.svh"

module edc_dp #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire edc_pkg::t_cmd               i_cmd,
    output edc_pkg::t_sts                    o_sts,
    input  wire logic                        i_operation,
    input  wire logic [edc_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic                        i_last,
    input  wire logic                        i_out_stall,
    output logic                             o_out_valid,
    output logic      [edc_pkg::DIST_W-1:0]  o_distance,
    output logic                             o_overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DW = (LW > edc_pkg::DIST_W) ? LW : edc_pkg::DIST_W;

    // Control state
    logic [LW-1:0] r_ref_len,     n_ref_len;
    logic          r_ref_ovf,     n_ref_ovf;
    logic          r_ref_closed,  n_ref_closed;
    logic          r_cand_active, n_cand_active;
    logic [LW-1:0] r_cand_len,    n_cand_len;
    logic          r_trunc,       n_trunc;
    logic          r_first,       n_first;
    logic          r_want,        n_want;
    logic          r_rd_on,       n_rd_on;
    logic          r_pv,          n_pv;
    logic          r_out_valid,   n_out_valid;

    // Payload
    logic [edc_pkg::SYM_W-1:0]  r_sym,     n_sym;
    logic [AW-1:0]              r_ra,      n_ra;
    logic [AW-1:0]              r_wa,      n_wa;
    logic [LW-1:0]              r_left,    n_left;
    logic [LW-1:0]              r_diag,    n_diag;
    logic [LW-1:0]              r_final,   n_final;
    logic [edc_pkg::DIST_W-1:0] r_dist,    n_dist;
    logic                       r_ovf_out, n_ovf_out;

    logic                      is_cand;
    logic [LW-1:0]             eff_rlen;
    logic [LW-1:0]             eff_clen;
    logic [LW-1:0]             clen_inc;
    logic                      ref_room;
    logic                      cand_room;
    logic [LW-1:0]             ref_last_idx;
    logic                      rd_en;
    logic                      rd_last;
    logic [edc_pkg::SYM_W-1:0] ref_rdata;
    logic [LW-1:0]             row_rdata;
    logic [LW-1:0]             row_up;
    logic [LW:0]               up1;
    logic [LW:0]               left1;
    logic [LW:0]               diag_c;
    logic [LW:0]               min_a;
    logic [LW:0]               min_b;
    logic [LW-1:0]             cell_v;
    logic                      cell_last;
    logic                      ref_we;
    logic                      row_we;
    logic [DW-1:0]             fin_ext;
    logic [edc_pkg::DIST_W-1:0] dist_sat;

    // Effective word lengths seen by the offered beat
    assign is_cand      = (i_operation == edc_pkg::OP_CAND);
    assign eff_rlen     = r_ref_closed ? '0 : r_ref_len;
    assign eff_clen     = r_cand_active ? r_cand_len : '0;
    assign clen_inc     = eff_clen + LW'(1);
    assign ref_room     = (eff_rlen < LW'(MAX_LEN));
    assign cand_room    = (eff_clen < LW'(MAX_LEN));
    assign ref_last_idx = r_ref_len - LW'(1);

    // Sweep read side
    assign rd_en   = i_cmd.step && r_rd_on;
    assign rd_last = (LW'(r_ra) == ref_last_idx);

    // One DP cell: min of insert, delete and substitute
    assign row_up = r_first ? (LW'(r_wa) + LW'(1)) : row_rdata;
    assign up1    = {1'b0, row_up} + (LW+1)'(1);
    assign left1  = {1'b0, r_left} + (LW+1)'(1);
    assign diag_c = {1'b0, r_diag} + ((ref_rdata == r_sym) ? (LW+1)'(0) : (LW+1)'(1));
    assign min_a  = (up1 < left1) ? up1 : left1;
    assign min_b  = (min_a < diag_c) ? min_a : diag_c;
    assign cell_v = min_b[LW-1:0];

    assign cell_last = r_pv && (LW'(r_wa) == ref_last_idx);
    assign row_we    = i_cmd.step && r_pv;
    assign ref_we    = i_cmd.take && !is_cand && ref_room;

    // Result saturation
    assign fin_ext  = DW'(r_final);
    assign dist_sat = (fin_ext > DW'(edc_pkg::DIST_SAT)) ? edc_pkg::DIST_SAT
                                                         : fin_ext[edc_pkg::DIST_W-1:0];

    // Status to controller
    assign o_sts.sweep_go  = is_cand && cand_room && (r_ref_len != '0);
    assign o_sts.res_now   = is_cand && i_last;
    assign o_sts.sweep_end = cell_last;
    assign o_sts.res_pend  = r_want;
    assign o_sts.out_busy  = r_out_valid && i_out_stall;

    // Next-state logic
    always_comb begin
        n_ref_len     = r_ref_len;
        n_ref_ovf     = r_ref_ovf;
        n_ref_closed  = r_ref_closed;
        n_cand_active = r_cand_active;
        n_cand_len    = r_cand_len;
        n_trunc       = r_trunc;
        n_first       = r_first;
        n_want        = r_want;
        n_rd_on       = r_rd_on;
        n_pv          = r_pv;
        n_out_valid   = r_out_valid;
        n_sym         = r_sym;
        n_ra          = r_ra;
        n_wa          = r_wa;
        n_left        = r_left;
        n_diag        = r_diag;
        n_final       = r_final;
        n_dist        = r_dist;
        n_ovf_out     = r_ovf_out;

        // accepted beat
        if (i_cmd.take) begin
            n_sym  = i_symbol;
            n_want = is_cand && i_last;
            if (!is_cand) begin
                // reference char: restart a closed word, abort any candidate
                n_ref_closed  = i_last;
                n_cand_active = 1'b0;
                n_ref_ovf     = (r_ref_closed ? 1'b0 : r_ref_ovf) | !ref_room;
                n_ref_len     = ref_room ? (eff_rlen + LW'(1)) : eff_rlen;
            end else begin
                n_ref_closed  = 1'b1;
                n_cand_active = !i_last;
                n_trunc       = (r_cand_active ? r_trunc : r_ref_ovf) | !cand_room;
                if (!r_cand_active) begin
                    n_first = 1'b1;
                end
                if (cand_room) begin
                    n_left  = clen_inc;
                    n_diag  = eff_clen;
                    n_ra    = '0;
                    n_rd_on = (r_ref_len != '0);
                    if (r_ref_len == '0) begin
                        // empty reference: distance is the candidate length
                        n_cand_len = clen_inc;
                        n_final    = clen_inc;
                    end else begin
                        n_cand_len = eff_clen;
                    end
                end
            end
        end

        // row sweep, one cell per cycle behind the memory read
        if (i_cmd.step) begin
            n_pv = r_rd_on;
            if (r_rd_on) begin
                n_wa = r_ra;
                if (rd_last) begin
                    n_rd_on = 1'b0;
                end else begin
                    n_ra = r_ra + AW'(1);
                end
            end
            if (r_pv) begin
                n_left = cell_v;
                n_diag = row_up;
                if (cell_last) begin
                    n_final    = cell_v;
                    n_cand_len = r_cand_len + LW'(1);
                    n_first    = 1'b0;
                end
            end
        end

        // result register
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_dist      = dist_sat;
            n_ovf_out   = r_trunc;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len     <= '0;
            r_ref_ovf     <= 1'b0;
            r_ref_closed  <= 1'b0;
            r_cand_active <= 1'b0;
            r_cand_len    <= '0;
            r_trunc       <= 1'b0;
            r_first       <= 1'b0;
            r_want        <= 1'b0;
            r_rd_on       <= 1'b0;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_ref_len     <= n_ref_len;
            r_ref_ovf     <= n_ref_ovf;
            r_ref_closed  <= n_ref_closed;
            r_cand_active <= n_cand_active;
            r_cand_len    <= n_cand_len;
            r_trunc       <= n_trunc;
            r_first       <= n_first;
            r_want        <= n_want;
            r_rd_on       <= n_rd_on;
            r_pv          <= n_pv;
            r_out_valid   <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_sym     <= n_sym;
        r_ra      <= n_ra;
        r_wa      <= n_wa;
        r_left    <= n_left;
        r_diag    <= n_diag;
        r_final   <= n_final;
        r_dist    <= n_dist;
        r_ovf_out <= n_ovf_out;
    end

    // Reference characters
    edc_ram #(
        .WIDTH (edc_pkg::SYM_W),
        .DEPTH (MAX_LEN)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (ref_we),
        .i_waddr (eff_rlen[AW-1:0]),
        .i_wdata (i_symbol),
        .i_re    (rd_en),
        .i_raddr (r_ra),
        .o_rdata (ref_rdata)
    );

    // Cost row, cells 1 to MAX_LEN (cell 0 is the candidate length)
    edc_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_LEN)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (r_wa),
        .i_wdata (cell_v),
        .i_re    (rd_en),
        .i_raddr (r_ra),
        .o_rdata (row_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_dist;
    assign o_overflow  = r_ovf_out;

    `EDC_ASSERT_NOW(a_rd_in_word, r_rd_on, LW'(r_ra) < r_ref_len, "read past reference end")
    `EDC_ASSERT_NOW(a_cell_nonempty, r_pv, r_ref_len != '0, "cell update with empty reference")
    `EDC_ASSERT_NEXT(a_sweep_drained, o_sts.sweep_end, !r_pv && !r_rd_on, "sweep not drained")

endmodule

`default_nettype wire

### src/edit_distance_engine_core.sv
// Top level of the Levenshtein edit distance engine.
// Reference characters (operation 0) are stored one per beat.
// Candidate characters (operation 1) update one dynamic-programming cost row held in
// a RAM: a beat is taken, then the row is swept one cell per cycle through the RAM
// read port across the stored reference characters; no sweep is run when the
// reference is empty or the candidate is already MAX_LEN long. The candidate's last
// character then loads the result register once it has room; the result waits there
// while the next beat is taken. Words longer than MAX_LEN are truncated and flagged in
// overflow; distance saturates at 127.
// The memories need no clearing after reset.
`default_nettype none

module edit_distance_engine_core #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_operation,
    input  wire logic [edc_pkg::SYM_W-1:0]   i_symbol,
    input  wire logic                        i_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [edc_pkg::DIST_W-1:0]  o_distance,
    output logic                             o_overflow
);

    edc_pkg::t_cmd cmd;
    edc_pkg::t_sts sts;

    // Sequencer
    edc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Word storage and cost-row datapath
    edc_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_operation),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_distance  (o_distance),
        .o_overflow  (o_overflow)
    );

endmodule

`default_nettype wire
